@@ src/stsu_pkg.sv @@
// ----------------------------------------------------------------------------
// stsu_pkg: shared definitions for the series trig and square root unit
// Operation and status codes, item layout, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package stsu_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int IW           = 64;   // internal Q7.56 word
   localparam int IFB          = 56;
   localparam int SIN_TERMS    = 20;
   localparam int ATAN_TERMS   = 30;
   localparam int NEWTON_STEPS = 60;

   localparam int REQ_BYTES = (3 + 2 * DATA_WIDTH + 7) / 8;
   localparam int RSP_BYTES = (DATA_WIDTH + 2 + 7) / 8;

   localparam logic [2:0] OP_SIN   = 3'd0;
   localparam logic [2:0] OP_COS   = 3'd1;
   localparam logic [2:0] OP_TAN   = 3'd2;
   localparam logic [2:0] OP_ATAN  = 3'd3;
   localparam logic [2:0] OP_ATAN2 = 3'd4;
   localparam logic [2:0] OP_SQRT  = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DOMAIN = 2'd1;
   localparam logic [1:0] ST_SAT    = 2'd2;

   localparam logic [63:0] PI_R60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] TWO_PI_R60  = 64'h6487ED5110B4611A;
   localparam logic [64:0] FOUR_PI_R60 = 65'h0C90FDAA22168C234;
   localparam logic [63:0] PI_I        = 64'h03243F6A8885A309;
   localparam logic [63:0] HALF_PI_I   = 64'h01921FB54442D184;
   localparam logic [63:0] ONE_I       = 64'h0100000000000000;
   localparam logic [63:0] TAN_POLE    = 64'd72;
   localparam logic [127:0] MUL_ROUND  = 128'd1 << (IFB - 1);

   // Magnitude of a two's complement internal word.
   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

@@ src/series_trig_sqrt_unit_top.sv @@
// ----------------------------------------------------------------------------
// series_trig_sqrt_unit_top: sin, cos, tan, atan, atan2 and sqrt in Q15.16
// A small sequencer drives one shared 32x32 multiplier and one bit-serial
// divider to sum Maclaurin series, reduce angles and run Newton iteration.
// ----------------------------------------------------------------------------
// Run time is set by the divider, which resolves one quotient bit a cycle and is
// used once per series term and Newton step; tan runs the sine and cosine series
// in turn, and domain errors go straight from dispatch to the output state.
// One item is in work at a time; the next is taken the cycle after the result
// moves into the output register. Reset (synchronous, active high) returns
// the sequencer to idle and drops any pending result.
module series_trig_sqrt_unit_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_tdata fields from bit 0: opcode[2:0], operand_a[31:0], operand_b[31:0]
   input  logic [stsu_pkg::REQ_BYTES*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata fields from bit 0: result_value[31:0], status[1:0]
   output logic [stsu_pkg::RSP_BYTES*8-1:0] rsp_tdata
);

   localparam int DW = stsu_pkg::DATA_WIDTH;
   localparam int FB = stsu_pkg::FRAC_BITS;
   localparam int IPB = DW - FB;

   // Sequencer states.
   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_DISP = 6'd1;
   localparam logic [5:0] S_RED  = 6'd2;
   localparam logic [5:0] S_RED1 = 6'd3;
   localparam logic [5:0] S_RED2 = 6'd4;
   localparam logic [5:0] S_RED3 = 6'd5;
   localparam logic [5:0] S_SC0  = 6'd6;
   localparam logic [5:0] S_SC1  = 6'd7;
   localparam logic [5:0] S_SC2  = 6'd8;
   localparam logic [5:0] S_SC3  = 6'd9;
   localparam logic [5:0] S_SC4  = 6'd10;
   localparam logic [5:0] S_SC5  = 6'd11;
   localparam logic [5:0] S_TAN0 = 6'd12;
   localparam logic [5:0] S_TAN1 = 6'd13;
   localparam logic [5:0] S_AR0  = 6'd14;
   localparam logic [5:0] S_AC0  = 6'd15;
   localparam logic [5:0] S_AC1  = 6'd16;
   localparam logic [5:0] S_SQ0  = 6'd17;
   localparam logic [5:0] S_SQ1  = 6'd18;
   localparam logic [5:0] S_SQ2  = 6'd19;
   localparam logic [5:0] S_SQD  = 6'd20;
   localparam logic [5:0] S_AC2  = 6'd21;
   localparam logic [5:0] S_AC3  = 6'd22;
   localparam logic [5:0] S_AC4  = 6'd23;
   localparam logic [5:0] S_AC5  = 6'd24;
   localparam logic [5:0] S_AC6  = 6'd25;
   localparam logic [5:0] S_AC7  = 6'd26;
   localparam logic [5:0] S_AC8  = 6'd27;
   localparam logic [5:0] S_AR1  = 6'd28;
   localparam logic [5:0] S_FIN  = 6'd29;
   localparam logic [5:0] S_ENC  = 6'd30;
   localparam logic [5:0] S_OUT  = 6'd31;
   localparam logic [5:0] S_MUL  = 6'd32;
   localparam logic [5:0] S_DIV  = 6'd33;

   // Control state.
   logic [5:0] state_ff, state_in, ret_ff, ret_in;
   logic rsp_valid_ff, rsp_valid_in;
   // Item and working registers.
   logic [2:0] op_ff, op_in;
   logic [DW-1:0] am_ff, am_in, bm_ff, bm_in, rn_ff, rn_in, rd_ff, rd_in;
   logic an_ff, an_in, bn_ff, bn_in;
   logic [63:0] red_ff, red_in, x_ff, x_in, x2_ff, x2_in, term_ff, term_in;
   logic [63:0] sum_ff, sum_in, s_ff, s_in, t_ff, t_in, sqn_ff, sqn_in;
   logic [63:0] g_ff, g_in, v_ff, v_in, enc_mag_ff, enc_mag_in;
   logic [$clog2(IPB)-1:0] rcnt_ff, rcnt_in;
   logic [4:0] k_ff, k_in;
   logic [5:0] it_ff, it_in;
   logic cosf_ff, cosf_in, tneg_ff, tneg_in, swap_ff, swap_in;
   logic enc_neg_ff, enc_neg_in;
   logic [DW-1:0] res_ff, res_in;
   logic [1:0] st_ff, st_in;
   logic [stsu_pkg::RSP_BYTES*8-1:0] rsp_data_ff, rsp_data_in;
   // Shared multiplier.
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in;
   logic mneg_ff, mneg_in, mlow_ff, mlow_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0] mcnt_ff, mcnt_in;
   // Shared divider.
   logic [63:0] dn_ff, dn_in, dd_ff, dd_in, dr_ff, dr_in, dq_ff, dq_in;
   logic dover_ff, dover_in;
   logic [6:0] dcnt_ff, dcnt_in, dtot_ff, dtot_in;

   // Unit requests raised by the sequencer.
   logic mul_go, m_neg, m_low, div_go;
   logic [63:0] m_a, m_b, d_num, d_den;
   logic [6:0] d_sh;
   logic [5:0] call_ret;

   logic [63:0] mmag, mul_res, div_res;
   logic [DW-1:0] a_raw, b_raw;

   assign mmag    = mlow_ff ? {1'b0, acc_ff[62:0]} : {1'b0, acc_ff[118:56]};
   assign mul_res = mneg_ff ? (64'd0 - mmag) : mmag;
   assign div_res = dover_ff ? '1 : dq_ff;
   assign a_raw   = req_tdata[3 +: DW];
   assign b_raw   = req_tdata[3 + DW +: DW];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [64:0] rt;
      logic [63:0] tmp, tt, one, nx, lim, cm;
      logic [31:0] sel_a, sel_b;
      logic [63:0] prod;
      logic [5:0] k2, odd;
      logic [11:0] den12;
      logic [6:0] sqsh;

      rt = '0; tmp = '0; tt = '0; one = '0; nx = '0; lim = '0; cm = '0;
      sel_a = '0; sel_b = '0; prod = '0; k2 = {k_ff, 1'b0}; odd = '0; den12 = '0;
      sqsh = (op_ff == stsu_pkg::OP_SQRT) ? 7'(FB) : 7'(stsu_pkg::IFB);

      state_in = state_ff; ret_in = ret_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      op_in = op_ff; am_in = am_ff; bm_in = bm_ff; an_in = an_ff; bn_in = bn_ff;
      rn_in = rn_ff; rd_in = rd_ff; red_in = red_ff; x_in = x_ff; x2_in = x2_ff;
      term_in = term_ff; sum_in = sum_ff; s_in = s_ff; t_in = t_ff; sqn_in = sqn_ff;
      g_in = g_ff; v_in = v_ff; enc_mag_in = enc_mag_ff; enc_neg_in = enc_neg_ff;
      rcnt_in = rcnt_ff; k_in = k_ff; it_in = it_ff; cosf_in = cosf_ff;
      tneg_in = tneg_ff; swap_in = swap_ff; res_in = res_ff; st_in = st_ff;
      rsp_data_in = rsp_data_ff;
      ma_in = ma_ff; mb_in = mb_ff; mneg_in = mneg_ff; mlow_in = mlow_ff;
      acc_in = acc_ff; mcnt_in = mcnt_ff;
      dn_in = dn_ff; dd_in = dd_ff; dr_in = dr_ff; dq_in = dq_ff;
      dover_in = dover_ff; dcnt_in = dcnt_ff; dtot_in = dtot_ff;

      mul_go = 1'b0; m_a = '0; m_b = '0; m_neg = 1'b0; m_low = 1'b0;
      div_go = 1'b0; d_num = '0; d_den = '0; d_sh = '0; call_ret = state_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[2:0];
               am_in = a_raw[DW-1] ? (DW'(0) - a_raw) : a_raw;
               bm_in = b_raw[DW-1] ? (DW'(0) - b_raw) : b_raw;
               an_in = a_raw[DW-1];
               bn_in = b_raw[DW-1];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            st_in = stsu_pkg::ST_OK;
            res_in = '0;
            cosf_in = (op_ff == stsu_pkg::OP_COS);
            case (op_ff)
               stsu_pkg::OP_SIN, stsu_pkg::OP_COS, stsu_pkg::OP_TAN: begin
                  red_in = '0;
                  rcnt_in = ($clog2(IPB))'(IPB - 1);
                  state_in = S_RED;
               end
               stsu_pkg::OP_ATAN: begin
                  rn_in = am_ff;
                  rd_in = DW'(1) << FB;
                  state_in = S_AR0;
               end
               stsu_pkg::OP_ATAN2: begin
                  if (am_ff == '0) begin
                     // On the y axis: zero at the origin, else plus or minus pi/2.
                     if (bm_ff == '0) v_in = '0;
                     else v_in = bn_ff ? (64'd0 - stsu_pkg::HALF_PI_I) : stsu_pkg::HALF_PI_I;
                     state_in = S_FIN;
                  end else begin
                     rn_in = bm_ff;
                     rd_in = am_ff;
                     state_in = S_AR0;
                  end
               end
               stsu_pkg::OP_SQRT: begin
                  if (an_ff) begin
                     st_in = stsu_pkg::ST_DOMAIN;
                     state_in = S_OUT;
                  end else begin
                     sqn_in = 64'(am_ff);
                     state_in = S_SQ0;
                  end
               end
               default: begin
                  st_in = stsu_pkg::ST_DOMAIN;
                  state_in = S_OUT;
               end
            endcase
         end
         // Integer part of the angle, one bit a cycle, modulo 2*pi in Q4.60.
         S_RED: begin
            rt = {red_ff, 1'b0} + (65'(am_ff[FB + 32'(rcnt_ff)]) << 60);
            if (rt >= stsu_pkg::FOUR_PI_R60) red_in = 64'(rt - stsu_pkg::FOUR_PI_R60);
            else if (rt >= {1'b0, stsu_pkg::TWO_PI_R60})
               red_in = 64'(rt - {1'b0, stsu_pkg::TWO_PI_R60});
            else red_in = rt[63:0];
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == '0) state_in = S_RED1;
         end
         S_RED1: begin
            tmp = red_ff + (64'(am_ff[FB-1:0]) << (60 - FB));
            red_in = (tmp >= stsu_pkg::TWO_PI_R60) ? tmp - stsu_pkg::TWO_PI_R60 : tmp;
            state_in = S_RED2;
         end
         S_RED2: begin
            // Fold into [0, pi] and carry the reflection in the sign.
            if (red_ff > stsu_pkg::PI_R60) begin
               red_in = stsu_pkg::TWO_PI_R60 - red_ff;
               an_in = ~an_ff;
            end
            state_in = S_RED3;
         end
         S_RED3: begin
            tmp = (red_ff + 64'd8) >> 4;
            x_in = an_ff ? (64'd0 - tmp) : tmp;
            state_in = S_SC0;
         end
         S_SC0: begin
            mul_go = 1'b1; m_a = stsu_pkg::mag64(x_ff); m_b = stsu_pkg::mag64(x_ff);
            call_ret = S_SC1;
         end
         S_SC1: begin
            x2_in = mul_res;
            term_in = cosf_ff ? stsu_pkg::ONE_I : x_ff;
            sum_in = cosf_ff ? stsu_pkg::ONE_I : x_ff;
            k_in = 5'd1;
            state_in = S_SC2;
         end
         S_SC2: begin
            mul_go = 1'b1; m_a = stsu_pkg::mag64(term_ff); m_b = x2_ff;
            m_neg = term_ff[63]; call_ret = S_SC3;
         end
         S_SC3: begin
            odd = cosf_ff ? k2 - 6'd1 : k2 + 6'd1;
            den12 = 12'(k2) * 12'(odd);
            tneg_in = ~mul_res[63];
            div_go = 1'b1; d_num = stsu_pkg::mag64(mul_res); d_den = 64'(den12);
            call_ret = S_SC4;
         end
         S_SC4: begin
            tt = tneg_ff ? (64'd0 - div_res) : div_res;
            term_in = tt;
            sum_in = sum_ff + tt;
            k_in = k_ff + 5'd1;
            state_in = (k_ff == 5'(stsu_pkg::SIN_TERMS - 1)) ? S_SC5 : S_SC2;
         end
         S_SC5: begin
            if (op_ff == stsu_pkg::OP_TAN && !cosf_ff) begin
               s_in = sum_ff;
               cosf_in = 1'b1;
               state_in = S_SC0;
            end else if (op_ff == stsu_pkg::OP_TAN) begin
               state_in = S_TAN0;
            end else begin
               v_in = sum_ff;
               state_in = S_FIN;
            end
         end
         S_TAN0: begin
            cm = stsu_pkg::mag64(sum_ff);
            if (cm < stsu_pkg::TAN_POLE) begin
               // Near a pole: signed full scale.
               st_in = stsu_pkg::ST_SAT;
               res_in = (!s_ff[63] && s_ff != '0) ? {1'b0, {(DW-1){1'b1}}}
                                                  : {1'b1, {(DW-1){1'b0}}};
               state_in = S_OUT;
            end else begin
               div_go = 1'b1; d_num = stsu_pkg::mag64(s_ff); d_den = cm;
               d_sh = 7'(FB + 1); call_ret = S_TAN1;
            end
         end
         S_TAN1: begin
            tmp = dq_ff + 64'd1;
            tt = dover_ff ? '1 : (tmp >> 1);
            enc_mag_in = tt;
            enc_neg_in = (s_ff[63] ^ sum_ff[63]) && (tt != '0);
            state_in = S_ENC;
         end
         S_AR0: begin
            if (rn_ff == '0) begin
               sum_in = '0;
               swap_in = 1'b0;
               state_in = S_AC8;
            end else begin
               div_go = 1'b1; d_sh = 7'(stsu_pkg::IFB); call_ret = S_AC0;
               swap_in = (rn_ff > rd_ff);
               d_num = (rn_ff > rd_ff) ? 64'(rd_ff) : 64'(rn_ff);
               d_den = (rn_ff > rd_ff) ? 64'(rn_ff) : 64'(rd_ff);
            end
         end
         S_AC0: begin
            t_in = div_res;
            mul_go = 1'b1; m_a = div_res; m_b = div_res; call_ret = S_AC1;
         end
         S_AC1: begin
            sqn_in = stsu_pkg::ONE_I + mul_res;
            state_in = S_SQ0;
         end
         // Newton square root from above.
         S_SQ0: begin
            one = 64'd1 << sqsh;
            if (sqn_ff == '0) begin
               g_in = '0;
               state_in = S_SQD;
            end else begin
               g_in = (sqn_ff >= one) ? sqn_ff : one;
               it_in = '0;
               state_in = S_SQ1;
            end
         end
         S_SQ1: begin
            div_go = 1'b1; d_num = sqn_ff; d_den = g_ff; d_sh = sqsh; call_ret = S_SQ2;
         end
         S_SQ2: begin
            nx = (g_ff >> 1) + (div_res >> 1) + 64'(g_ff[0] & div_res[0]);
            if (dover_ff || nx >= g_ff) begin
               state_in = S_SQD;
            end else begin
               g_in = nx;
               it_in = it_ff + 6'd1;
               state_in = (it_ff == 6'(stsu_pkg::NEWTON_STEPS - 1)) ? S_SQD : S_SQ1;
            end
         end
         S_SQD: begin
            if (op_ff == stsu_pkg::OP_SQRT) begin
               enc_neg_in = 1'b0;
               enc_mag_in = g_ff;
               state_in = S_ENC;
            end else begin
               // Half-angle step: t / (1 + sqrt(1 + t^2)).
               div_go = 1'b1; d_num = t_ff; d_den = stsu_pkg::ONE_I + g_ff;
               d_sh = 7'(stsu_pkg::IFB); call_ret = S_AC2;
            end
         end
         S_AC2: begin
            term_in = div_res;
            sum_in = div_res;
            k_in = 5'd1;
            mul_go = 1'b1; m_a = stsu_pkg::mag64(div_res); m_b = stsu_pkg::mag64(div_res);
            call_ret = S_AC3;
         end
         S_AC3: begin
            x2_in = mul_res;
            state_in = S_AC4;
         end
         S_AC4: begin
            mul_go = 1'b1; m_a = stsu_pkg::mag64(term_ff); m_b = x2_ff;
            m_neg = term_ff[63]; call_ret = S_AC5;
         end
         S_AC5: begin
            mul_go = 1'b1; m_a = stsu_pkg::mag64(mul_res); m_b = 64'(k2 - 6'd1);
            m_neg = mul_res[63]; m_low = 1'b1; call_ret = S_AC6;
         end
         S_AC6: begin
            tneg_in = ~mul_res[63];
            div_go = 1'b1; d_num = stsu_pkg::mag64(mul_res); d_den = 64'(k2 + 6'd1);
            call_ret = S_AC7;
         end
         S_AC7: begin
            tt = tneg_ff ? (64'd0 - div_res) : div_res;
            term_in = tt;
            sum_in = sum_ff + tt;
            k_in = k_ff + 5'd1;
            // The series stops once a term has vanished or k reaches ATAN_TERMS.
            state_in = (tt == '0 || k_ff == 5'(stsu_pkg::ATAN_TERMS)) ? S_AC8 : S_AC4;
         end
         S_AC8: begin
            tmp = {sum_ff[62:0], 1'b0};
            x_in = swap_ff ? (stsu_pkg::HALF_PI_I - tmp) : tmp;
            state_in = S_AR1;
         end
         S_AR1: begin
            if (op_ff == stsu_pkg::OP_ATAN) v_in = an_ff ? (64'd0 - x_ff) : x_ff;
            else if (!an_ff) v_in = bn_ff ? (64'd0 - x_ff) : x_ff;
            else v_in = bn_ff ? (x_ff - stsu_pkg::PI_I) : (stsu_pkg::PI_I - x_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            tmp = stsu_pkg::mag64(v_ff) + (64'd1 << (stsu_pkg::IFB - FB - 1));
            enc_mag_in = tmp >> (stsu_pkg::IFB - FB);
            enc_neg_in = v_ff[63];
            state_in = S_ENC;
         end
         S_ENC: begin
            lim = enc_neg_ff ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 64'd1);
            tmp = enc_mag_ff;
            if (tmp > lim) begin
               tmp = lim;
               st_in = stsu_pkg::ST_SAT;
            end
            res_in = enc_neg_ff ? (DW'(0) - tmp[DW-1:0]) : tmp[DW-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = (stsu_pkg::RSP_BYTES*8)'({st_ff, res_ff});
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         // One 32x32 partial product a cycle into the 128-bit accumulator.
         S_MUL: begin
            sel_a = mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
            sel_b = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
            prod = 64'(sel_a) * 64'(sel_b);
            case ({1'b0, mcnt_ff[1]} + {1'b0, mcnt_ff[0]})
               2'd0:    acc_in = acc_ff + {64'd0, prod};
               2'd1:    acc_in = acc_ff + {32'd0, prod, 32'd0};
               default: acc_in = acc_ff + {prod, 64'd0};
            endcase
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) state_in = ret_ff;
         end
         // Restoring division, one quotient bit a cycle.
         S_DIV: begin
            rt = {dr_ff, dn_ff[63]};
            dn_in = {dn_ff[62:0], 1'b0};
            if (dq_ff[63]) dover_in = 1'b1;
            if (rt[64] || rt[63:0] >= dd_ff) begin
               dr_in = rt[63:0] - dd_ff;
               dq_in = {dq_ff[62:0], 1'b1};
            end else begin
               dr_in = rt[63:0];
               dq_in = {dq_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == dtot_ff - 7'd1) state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase

      if (mul_go) begin
         ma_in = m_a; mb_in = m_b; mneg_in = m_neg; mlow_in = m_low;
         acc_in = m_low ? '0 : stsu_pkg::MUL_ROUND;
         mcnt_in = '0;
         ret_in = call_ret;
         state_in = S_MUL;
      end
      if (div_go) begin
         ret_in = call_ret;
         if (d_den == '0) begin
            // Division by zero reports overflow at once.
            dover_in = 1'b1;
            state_in = call_ret;
         end else begin
            dn_in = d_num; dd_in = d_den; dr_in = '0; dq_in = '0; dover_in = 1'b0;
            dcnt_in = '0; dtot_in = 7'd64 + d_sh;
            state_in = S_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in; op_ff <= op_in; am_ff <= am_in; bm_ff <= bm_in;
      an_ff <= an_in; bn_ff <= bn_in; rn_ff <= rn_in; rd_ff <= rd_in;
      red_ff <= red_in; x_ff <= x_in; x2_ff <= x2_in; term_ff <= term_in;
      sum_ff <= sum_in; s_ff <= s_in; t_ff <= t_in; sqn_ff <= sqn_in;
      g_ff <= g_in; v_ff <= v_in; enc_mag_ff <= enc_mag_in; enc_neg_ff <= enc_neg_in;
      rcnt_ff <= rcnt_in; k_ff <= k_in; it_ff <= it_in; cosf_ff <= cosf_in;
      tneg_ff <= tneg_in; swap_ff <= swap_in; res_ff <= res_in; st_ff <= st_in;
      rsp_data_ff <= rsp_data_in;
      ma_ff <= ma_in; mb_ff <= mb_in; mneg_ff <= mneg_in; mlow_ff <= mlow_in;
      acc_ff <= acc_in; mcnt_ff <= mcnt_in;
      dn_ff <= dn_in; dd_ff <= dd_in; dr_ff <= dr_in; dq_ff <= dq_in;
      dover_ff <= dover_in; dcnt_ff <= dcnt_in; dtot_ff <= dtot_in;
   end

   // An accepted item keeps the input closed on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again while an item is in work");

   // A new result only ever comes from the output state.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == S_OUT))
      else $error("result raised outside the output state");

   // The divider never runs past its programmed length.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff < dtot_ff))
      else $error("divider step count overran");

   // A finished multiply hands control back to its caller.
   a_mul_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && mcnt_ff == 2'd3) |=> (state_ff == $past(ret_ff)))
      else $error("multiply did not return to its caller");

   // Status never takes the unused code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DW+1:DW] != 2'd3))
      else $error("result carries an unused status code");

endmodule
